@@ hw/rtl/lphm_pkg.sv @@
package lphm_pkg;

  localparam int TableSize = 1024;
  localparam int KeyBits = 32;
  localparam int ValueBits = 32;

  // operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NOP = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_KEY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [63:0] key;
    logic [63:0] value;
    logic zero_key;
    logic no_op;
  } req_t;

endpackage

@@ hw/rtl/lphm_front.sv @@
module lphm_front #(
  parameter int KEY_BITS = lphm_pkg::KeyBits,
  parameter int VALUE_BITS = lphm_pkg::ValueBits
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] kind,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic busy,
  output lphm_pkg::req_t q_data,
  output logic q_valid,
  input  logic q_pop
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  lphm_pkg::req_t req;
  lphm_pkg::req_t slot0;
  lphm_pkg::req_t slot1;
  logic [1:0] fill;

  // mask and classify the incoming request
  always_comb begin
    req = '0;
    req.kind = kind;
    req.key[KW-1:0] = key[KW-1:0];
    req.value[VW-1:0] = value[VW-1:0];
    req.no_op = (kind == lphm_pkg::KIND_NOP);
    req.zero_key = !req.no_op && (key[KW-1:0] == '0);
  end

  assign busy = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_data = slot0;

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      if (start && !busy && !(q_pop && q_valid)) begin
        fill <= fill + 2'd1;
      end else if (!(start && !busy) && q_pop && q_valid) begin
        fill <= fill - 2'd1;
      end
    end
    if (q_pop && q_valid) begin
      slot0 <= slot1;
      if (start && !busy && fill == 2'd1) slot0 <= req;
      if (start && !busy && fill == 2'd2) slot1 <= req;
    end else if (start && !busy) begin
      if (fill == 2'd0) slot0 <= req;
      else slot1 <= req;
    end
  end

endmodule

@@ hw/rtl/lphm_back.sv @@
module lphm_back #(
  parameter int TABLE_SIZE = lphm_pkg::TableSize,
  parameter int KEY_BITS = lphm_pkg::KeyBits,
  parameter int VALUE_BITS = lphm_pkg::ValueBits
) (
  input  logic clk,
  input  logic rst,
  input  lphm_pkg::req_t q_data,
  input  logic q_valid,
  output logic q_pop,
  output logic done,
  output logic found,
  output logic [31:0] data,
  output logic [1:0] status
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_SRD   = 9'b000010000,
    S_SCHK  = 9'b000100000,
    S_MOVE  = 9'b001000000,
    S_WRV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [KW-1:0] kmem [TABLE_SIZE];
  logic [VW-1:0] vmem [TABLE_SIZE];
  logic [KW-1:0] krd;
  logic [VW-1:0] vrd;
  logic [AW-1:0] raddr;
  logic [AW-1:0] slot;
  logic [AW-1:0] hole;
  logic [AW-1:0] clr;
  logic [CW-1:0] steps;
  lphm_pkg::req_t cur;
  logic kwe;
  logic vwe;
  logic [AW-1:0] waddr;
  logic [KW-1:0] kwd;
  logic [VW-1:0] vwd;
  logic [AW-1:0] slot_inc;
  logic [AW-1:0] home_j;
  logic [AW-1:0] d_home;
  logic [AW-1:0] d_hole;

  // wrap-around increment; table size need not be a power of two
  assign slot_inc = (slot == AW'(TABLE_SIZE - 1)) ? '0 : slot + AW'(1);
  assign home_j = AW'(krd % TABLE_SIZE);
  assign d_home = (slot >= home_j) ? slot - home_j : AW'(TABLE_SIZE) - (home_j - slot);
  assign d_hole = (slot >= hole) ? slot - hole : AW'(TABLE_SIZE) - (hole - slot);

  // table memories
  always_ff @(posedge clk) begin
    if (kwe) kmem[waddr] <= kwd;
    if (vwe) vmem[waddr] <= vwd;
    krd <= kmem[raddr];
    vrd <= vmem[raddr];
  end

  // memory write and read address selection
  always_comb begin
    kwe = 1'b0;
    vwe = 1'b0;
    waddr = slot;
    kwd = cur.key[KW-1:0];
    vwd = cur.value[VW-1:0];
    raddr = slot;
    case (state)
      S_CLEAR: begin
        kwe = 1'b1;
        waddr = clr;
        kwd = '0;
      end
      S_MOVE: begin
        kwe = 1'b1;
        vwe = 1'b1;
        waddr = hole;
        kwd = krd;
        vwd = vrd;
        raddr = slot_inc;
      end
      S_SCHK: begin
        raddr = slot_inc;
        // read the moving entry again so it is on krd/vrd in S_MOVE
        if (krd != '0 && steps != CW'(TABLE_SIZE) && d_home >= d_hole) raddr = slot;
      end
      S_WRV: begin
        kwe = (krd == '0) || cur.kind == lphm_pkg::KIND_REMOVE;
        vwe = cur.kind == lphm_pkg::KIND_INSERT;
        waddr = (cur.kind == lphm_pkg::KIND_REMOVE) ? hole : slot;
        kwd = (cur.kind == lphm_pkg::KIND_REMOVE) ? '0 : cur.key[KW-1:0];
      end
      default: ;
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // probe and shift sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TABLE_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          cur <= q_data;
          found <= 1'b0;
          data <= '0;
          status <= lphm_pkg::ST_OK;
          slot <= AW'(q_data.key[KW-1:0] % TABLE_SIZE);
          steps <= '0;
          if (q_data.zero_key) begin
            status <= lphm_pkg::ST_ZERO_KEY;
            state <= S_DONE;
          end else if (q_data.no_op) state <= S_DONE;
          else state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (krd == cur.key[KW-1:0]) begin
            found <= 1'b1;
            data <= 32'(vrd);
            if (cur.kind == lphm_pkg::KIND_INSERT) state <= S_WRV;
            else if (cur.kind == lphm_pkg::KIND_REMOVE) begin
              hole <= slot;
              slot <= slot_inc;
              steps <= CW'(1);
              state <= S_SRD;
            end else state <= S_DONE;
          end else if (krd == '0) begin
            if (cur.kind == lphm_pkg::KIND_INSERT) state <= S_WRV;
            else state <= S_DONE;
          end else if (steps == CW'(TABLE_SIZE - 1)) begin
            if (cur.kind == lphm_pkg::KIND_INSERT) status <= lphm_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            slot <= slot_inc;
            steps <= steps + CW'(1);
            state <= S_RD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          // krd/vrd hold entry at slot; decide whether it moves into the hole
          if (krd == '0 || steps == CW'(TABLE_SIZE)) state <= S_WRV;
          else if (d_home >= d_hole) state <= S_MOVE;
          else begin
            slot <= slot_inc;
            steps <= steps + CW'(1);
            state <= S_SCHK;
          end
        end
        S_MOVE: begin
          hole <= slot;
          slot <= slot_inc;
          steps <= steps + CW'(1);
          state <= S_SCHK;
        end
        S_WRV: state <= S_DONE;
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/linear_probe_hash_map_top.sv @@
// lookup and insert probe slots from the key's home slot; an insert adds a
// table write, and a remove also closes the gap, scanning occupied slots
// and moving entries back into the hole
// only one request at a time is worked through the table
// reset: clears the key table while the 2-entry queue takes up to 2 requests,
// then busy; results are a one-cycle done strobe, the receiver cannot stall
module linear_probe_hash_map_top #(
  parameter int TABLE_SIZE = lphm_pkg::TableSize,
  parameter int KEY_BITS = lphm_pkg::KeyBits,
  parameter int VALUE_BITS = lphm_pkg::ValueBits
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] kind,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic done,
  output logic found,
  output logic [31:0] data,
  output logic [1:0] status
);

  lphm_pkg::req_t q_data;
  logic q_valid;
  logic q_pop;

  // request queue
  lphm_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .start, .kind, .key, .value, .busy,
    .q_data, .q_valid, .q_pop
  );

  // table engine
  lphm_back #(.TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_pop, .done, .found, .data, .status
  );

endmodule

@@ tb/sv/tb_linear_probe_hash_map_top.sv @@
module tb_linear_probe_hash_map_top;

  localparam int Slots = lphm_pkg::TableSize;
  localparam int StallLimit = 20000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] kind;
  logic [31:0] key;
  logic [31:0] value;
  logic done;
  logic found;
  logic [31:0] data;
  logic [1:0] status;

  linear_probe_hash_map_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .key(key),
    .value(value), .done(done), .found(found), .data(data), .status(status)
  );

  // clock, 20 units per period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic found;
    logic [31:0] data;
    logic [1:0] status;
  } answer_t;

  typedef struct {
    logic [1:0] kind;
    logic [31:0] key;
    logic [31:0] value;
    bit typed;
    answer_t ans;
  } row_t;

  // shadow table
  logic [31:0] shadow_key [Slots];
  logic [31:0] shadow_val [Slots];
  int shadow_count;

  answer_t pending_q[$];
  int errors;
  int accepted;
  int checked;
  int idle_cycles;
  int send_idle_pct;
  int hits;
  int fulls;
  int zeros;
  logic [31:0] live_keys[$];

  function automatic int home_of(logic [31:0] k);
    return int'(k % Slots);
  endfunction

  function automatic int wrap_dist(int a, int b);
    return (b >= a) ? b - a : Slots - (a - b);
  endfunction

  // backward shift to close the hole left by a removal
  function automatic void close_hole(int hole);
    int j;
    logic [31:0] k;
    j = (hole + 1) % Slots;
    for (int i = 1; i < Slots; i++) begin
      k = shadow_key[j];
      if (k == 32'd0) break;
      if (wrap_dist(home_of(k), j) >= wrap_dist(hole, j)) begin
        shadow_key[hole] = k;
        shadow_val[hole] = shadow_val[j];
        hole = j;
      end
      j = (j + 1) % Slots;
    end
    shadow_key[hole] = 32'd0;
    shadow_val[hole] = 32'd0;
  endfunction

  function automatic answer_t map_apply(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    answer_t a;
    int s;
    int hit;
    a.found = 1'b0;
    a.data = 32'd0;
    a.status = lphm_pkg::ST_OK;
    if (op == lphm_pkg::KIND_NOP) return a;
    if (k == 32'd0) begin
      a.status = lphm_pkg::ST_ZERO_KEY;
      return a;
    end
    s = home_of(k);
    hit = 2;
    for (int i = 0; i < Slots; i++) begin
      if (shadow_key[s] == k) begin hit = 1; break; end
      if (shadow_key[s] == 32'd0) begin hit = 0; break; end
      s = (s + 1) % Slots;
    end
    if (hit == 1) begin
      a.found = 1'b1;
      a.data = shadow_val[s];
    end
    case (op)
      lphm_pkg::KIND_INSERT: begin
        if (hit == 1) begin
          shadow_val[s] = v;
        end else if (hit == 0) begin
          shadow_key[s] = k;
          shadow_val[s] = v;
          shadow_count++;
        end else begin
          a.status = lphm_pkg::ST_FULL;
        end
      end
      lphm_pkg::KIND_REMOVE: begin
        if (hit == 1) begin
          if (shadow_count > 0) shadow_count--;
          close_hole(s);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // send one request; the prediction is queued unless the answer is typed in, which is checked against it
  task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                              bit typed, answer_t ans);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= op;
    key <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = map_apply(op, k, v);
    if (typed && a != ans) begin
      $display("%0t typed row disagrees: expected %0d/%h/%0d predicted %0d/%h/%0d",
               $time, ans.found, ans.data, ans.status, a.found, a.data, a.status);
      errors++;
    end
    pending_q.push_back(typed ? ans : a);
    accepted++;
    if (a.found) hits++;
    if (a.status == lphm_pkg::ST_FULL) fulls++;
    if (a.status == lphm_pkg::ST_ZERO_KEY) zeros++;
    if (op == lphm_pkg::KIND_INSERT && k != 0) live_keys.push_back(k);
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: found %0d data %h status %0d",
                 $time, found, data, status);
        errors++;
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (found !== e.found) begin
          $display("%0t found mismatch: expected %0d actual %0d", $time, e.found, found);
          errors++;
        end
        if (data !== e.data) begin
          $display("%0t data mismatch: expected %h actual %h", $time, e.data, data);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t watchdog expired with %0d results pending", $time, pending_q.size());
      $display("linear_probe_hash_map_top regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key(int mode);
    logic [31:0] k;
    case (mode)
      0: k = $urandom();
      1: k = ($urandom_range(15) << 10) | $urandom_range(7);
      default: k = (live_keys.size() > 0) ?
                   live_keys[$urandom_range(live_keys.size() - 1)] : $urandom();
    endcase
    return k;
  endfunction

  function automatic answer_t mk(logic f, logic [31:0] d, logic [1:0] st);
    answer_t a;
    a.found = f;
    a.data = d;
    a.status = st;
    return a;
  endfunction

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  row_t plan[$];
  answer_t none;

  initial begin
    int phase_pct [4];
    logic [1:0] op;
    int pick;
    errors = 0;
    accepted = 0;
    checked = 0;
    hits = 0;
    fulls = 0;
    zeros = 0;
    idle_cycles = 0;
    shadow_count = 0;
    send_idle_pct = 0;
    for (int i = 0; i < Slots; i++) begin
      shadow_key[i] = 32'd0;
      shadow_val[i] = 32'd0;
    end
    none = mk(1'b0, 32'd0, lphm_pkg::ST_OK);
    rst = 1'b1;
    start = 1'b0;
    kind = 2'd0;
    key = 32'd0;
    value = 32'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table: empty map, zero keys, extremes, chains, shift on remove
    plan = '{
      '{lphm_pkg::KIND_LOOKUP, 32'h0000_0005, 32'h0, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_OK)},
      '{lphm_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_OK)},
      '{lphm_pkg::KIND_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_ZERO_KEY)},
      '{lphm_pkg::KIND_LOOKUP, 32'h0, 32'h0, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_ZERO_KEY)},
      '{lphm_pkg::KIND_REMOVE, 32'h0, 32'h0, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_ZERO_KEY)},
      '{lphm_pkg::KIND_NOP, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_OK)},
      '{lphm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        mk(1'b0, 32'h0, lphm_pkg::ST_OK)},
      '{lphm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1,
        mk(1'b1, 32'hFFFF_FFFF, lphm_pkg::ST_OK)},
      '{lphm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b1,
        mk(1'b1, 32'hFFFF_FFFF, lphm_pkg::ST_OK)},
      '{lphm_pkg::KIND_INSERT, 32'h0000_0001, 32'h0000_0011, 1'b0, none},
      '{lphm_pkg::KIND_INSERT, 32'h0000_0401, 32'h0000_0022, 1'b0, none},
      '{lphm_pkg::KIND_INSERT, 32'h0000_0801, 32'h0000_0033, 1'b0, none},
      '{lphm_pkg::KIND_INSERT, 32'h0000_0002, 32'h0000_0044, 1'b0, none},
      '{lphm_pkg::KIND_INSERT, 32'h0000_03FF, 32'hA5A5_A5A5, 1'b0, none},
      '{lphm_pkg::KIND_INSERT, 32'h0000_07FF, 32'h5A5A_5A5A, 1'b0, none},
      '{lphm_pkg::KIND_REMOVE, 32'h0000_0001, 32'h0, 1'b0, none},
      '{lphm_pkg::KIND_LOOKUP, 32'h0000_0801, 32'h0, 1'b0, none},
      '{lphm_pkg::KIND_LOOKUP, 32'h0000_0002, 32'h0, 1'b0, none},
      '{lphm_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0, none},
      '{lphm_pkg::KIND_LOOKUP, 32'h0000_07FF, 32'h0, 1'b0, none},
      '{lphm_pkg::KIND_REMOVE, 32'h0000_0401, 32'h0, 1'b0, none},
      '{lphm_pkg::KIND_LOOKUP, 32'h0000_0801, 32'h0, 1'b0, none}
    };
    foreach (plan[i])
      send_request(plan[i].kind, plan[i].key, plan[i].value, plan[i].typed, plan[i].ans);

    // hold off until the map has answered everything
    wait_drained();

    // random phases with sender idle rates of 0, 76, 0 and 11 percent
    phase_pct = '{0, 76, 0, 11};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p];
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        op = (pick < 45) ? lphm_pkg::KIND_INSERT : (pick < 75) ? lphm_pkg::KIND_LOOKUP :
             (pick < 97) ? lphm_pkg::KIND_REMOVE : lphm_pkg::KIND_NOP;
        send_request(op, ($urandom_range(49) == 0) ? 32'd0 : pick_key($urandom_range(2)),
                     $urandom(), 1'b0, none);
      end
      wait_drained();
    end

    // fill the table to reach the full status, then drain some entries
    send_idle_pct = 0;
    while (shadow_count < Slots) send_request(lphm_pkg::KIND_INSERT, $urandom() | 32'd1,
                                              $urandom(), 1'b0, none);
    for (int n = 0; n < 20; n++) begin
      send_request(lphm_pkg::KIND_INSERT, $urandom() | 32'd1, $urandom(), 1'b0, none);
      send_request(lphm_pkg::KIND_INSERT, pick_key(2), $urandom(), 1'b0, none);
      send_request(lphm_pkg::KIND_LOOKUP, $urandom(), 32'h0, 1'b0, none);
    end
    for (int n = 0; n < 100; n++)
      send_request(($urandom_range(1) == 0) ? lphm_pkg::KIND_REMOVE : lphm_pkg::KIND_INSERT,
                   pick_key(2), $urandom(), 1'b0, none);

    wait_drained();
    repeat (64) @(posedge clk);

    $display("covered directed rows, four idle phases, a full table and removals after it");
    $display("requests %0d, results checked %0d, hits %0d, zero-key %0d, full %0d",
             accepted, checked, hits, zeros, fulls);
    if (errors == 0 && pending_q.size() == 0)
      $display("linear_probe_hash_map_top regression: pass");
    else
      $display("linear_probe_hash_map_top regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_front.sv
hw/rtl/lphm_back.sv
hw/rtl/linear_probe_hash_map_top.sv
tb/sv/tb_linear_probe_hash_map_top.sv
